/* src/pp_pkg.sv */
`default_nettype none
package pp_pkg;

   localparam int MAX_DIM     = 256;
   localparam int DIM_W       = 9;
   localparam int COORD_W     = 16;
   localparam int TR_W        = COORD_W + 1;      // translated coordinate
   localparam int PROD_W      = TR_W + DIM_W + 1; // tx*h, tz*w
   localparam int SUM_W       = PROD_W + 1;       // tx*h + tz*w
   localparam int NUM_W       = SUM_W + DIM_W - 2; // signed numerator
   localparam int MAG_W       = NUM_W - 1;        // numerator magnitude
   localparam int DEN_W       = 25;               // 2*tz*w
   localparam int NUM_CELLS   = 18;               // quotient bits, top one flags saturation
   localparam int DIV_W       = DEN_W + NUM_CELLS - 1;
   localparam int PIPE_DEPTH  = 5 + NUM_CELLS + 2;
   localparam int ADDR_W      = 5;
   localparam int DATA_W      = 32;

   typedef enum logic [2:0] {
      REG_SCREEN_WIDTH  = 3'd0,
      REG_SCREEN_HEIGHT = 3'd1,
      REG_SHIFT_X       = 3'd2,
      REG_SHIFT_Y       = 3'd3,
      REG_SHIFT_Z       = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [DIM_W-1:0]          width;
      logic [DIM_W-1:0]          height;
      logic signed [COORD_W-1:0] shift_x;
      logic signed [COORD_W-1:0] shift_y;
      logic signed [COORD_W-1:0] shift_z;
   } cfg_type;

   // One word in flight through the divider chain; both axes share the divisor.
   typedef struct packed {
      logic                  front;
      logic                  neg_x;
      logic                  neg_y;
      logic [MAG_W-1:0]      rem_x;
      logic [MAG_W-1:0]      rem_y;
      logic [DIV_W-1:0]      divisor;
      logic [NUM_CELLS-1:0]  quo_x;
      logic [NUM_CELLS-1:0]  quo_y;
   } cell_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) r = DIM_W'(1);
      else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
      return r;
   endfunction

endpackage
`default_nettype wire

/* src/pp_cell.sv */
`default_nettype none
module pp_cell (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 valid_in,
   input  pp_pkg::cell_type    cell_in,
   output logic                valid_out,
   output pp_pkg::cell_type    cell_out
);
   import pp_pkg::*;

   logic     valid_ff;
   cell_type cell_ff, cell_in_nx;
   logic     ge_x, ge_y;

   // One restoring step for each axis.
   always_comb begin
      cell_in_nx = cell_in;
      ge_x = {{(DIV_W-MAG_W){1'b0}}, cell_in.rem_x} >= cell_in.divisor;
      ge_y = {{(DIV_W-MAG_W){1'b0}}, cell_in.rem_y} >= cell_in.divisor;
      if (ge_x) cell_in_nx.rem_x = MAG_W'(cell_in.rem_x - cell_in.divisor[MAG_W-1:0]);
      if (ge_y) cell_in_nx.rem_y = MAG_W'(cell_in.rem_y - cell_in.divisor[MAG_W-1:0]);
      cell_in_nx.quo_x   = {cell_in.quo_x[NUM_CELLS-2:0], ge_x};
      cell_in_nx.quo_y   = {cell_in.quo_y[NUM_CELLS-2:0], ge_y};
      cell_in_nx.divisor = cell_in.divisor >> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in_nx;
   end

   assign valid_out = valid_ff;
   assign cell_out  = cell_ff;
endmodule
`default_nettype wire

/* src/pp_csr.sv */
`default_nettype none
module pp_csr (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         csr_psel,
   input  wire                         csr_penable,
   input  wire                         csr_pwrite,
   input  wire  [pp_pkg::ADDR_W-1:0]   csr_paddr,
   input  wire  [pp_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [pp_pkg::DATA_W-1:0]   csr_prdata,
   output logic                        csr_pready,
   output pp_pkg::cfg_type             cfg
);
   import pp_pkg::*;

   logic [DIM_W-1:0]   width_ff, height_ff;
   logic [COORD_W-1:0] shift_x_ff, shift_y_ff, shift_z_ff;
   logic               wr;
   reg_index_type      idx;

   assign idx = reg_index_type'(csr_paddr[ADDR_W-1:2]);
   assign wr  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= DIM_W'(80);
         height_ff  <= DIM_W'(24);
         shift_x_ff <= '0;
         shift_y_ff <= '0;
         shift_z_ff <= COORD_W'(4096);
      end else if (wr) begin
         case (idx)
            REG_SCREEN_WIDTH:  width_ff   <= csr_pwdata[DIM_W-1:0];
            REG_SCREEN_HEIGHT: height_ff  <= csr_pwdata[DIM_W-1:0];
            REG_SHIFT_X:       shift_x_ff <= csr_pwdata[COORD_W-1:0];
            REG_SHIFT_Y:       shift_y_ff <= csr_pwdata[COORD_W-1:0];
            REG_SHIFT_Z:       shift_z_ff <= csr_pwdata[COORD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_SCREEN_WIDTH:  csr_prdata = DATA_W'(width_ff);
         REG_SCREEN_HEIGHT: csr_prdata = DATA_W'(height_ff);
         REG_SHIFT_X:       csr_prdata = DATA_W'(shift_x_ff);
         REG_SHIFT_Y:       csr_prdata = DATA_W'(shift_y_ff);
         REG_SHIFT_Z:       csr_prdata = DATA_W'(shift_z_ff);
         default:           csr_prdata = '0;
      endcase
   end

   assign csr_pready  = 1'b1;
   assign cfg.width   = clamp_dim(width_ff);
   assign cfg.height  = clamp_dim(height_ff);
   assign cfg.shift_x = $signed(shift_x_ff);
   assign cfg.shift_y = $signed(shift_y_ff);
   assign cfg.shift_z = $signed(shift_z_ff);
endmodule
`default_nettype wire

/* src/point_perspective_project.sv */
// Perspective projection of one vertex to a pixel.
// Input: pulse start with req_vertex_x/y/z (signed Q4.12); a word is taken
// at any edge where start is high and busy is low. busy never rises, so one
// vertex may enter every cycle.
// Output: done is high for one cycle with rsp_pixel_x/y, rsp_in_front,
// rsp_on_screen and rsp_pixel_index. The receiver cannot stall; every word
// comes out exactly once, in order.
// Pipeline: five front stages, an 18-cell divider chain that retires one quotient
// bit per cell, a saturation stage and the output register. Throughput: one
// word/cycle.
// Config: APB-style csr_ port, registers at byte 4*i (width, height,
// shift_x, shift_y, shift_z). Write only while idle.
// Reset (synchronous) clears all stage valids and restores register
// defaults 80, 24, 0, 0, 1.0; words in flight are dropped.
`default_nettype none
module point_perspective_project (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  wire  signed [15:0]           req_vertex_x,
   input  wire  signed [15:0]           req_vertex_y,
   input  wire  signed [15:0]           req_vertex_z,
   output logic                         done,
   output logic signed [15:0]           rsp_pixel_x,
   output logic signed [15:0]           rsp_pixel_y,
   output logic                         rsp_in_front,
   output logic                         rsp_on_screen,
   output logic [15:0]                  rsp_pixel_index,
   input  wire                          csr_psel,
   input  wire                          csr_penable,
   input  wire                          csr_pwrite,
   input  wire  [pp_pkg::ADDR_W-1:0]    csr_paddr,
   input  wire  [pp_pkg::DATA_W-1:0]    csr_pwdata,
   output logic [pp_pkg::DATA_W-1:0]    csr_prdata,
   output logic                         csr_pready
);
   import pp_pkg::*;

   cfg_type cfg;

   pp_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .cfg
   );

   assign busy = 1'b0;

   // valid per front stage
   logic [4:0] vld_ff;
   logic       front1_ff, front2_ff, front3_ff;

   // stage 1: translate
   logic signed [TR_W-1:0] tx_ff, ty_ff, tz_ff;
   // stage 2: scale tx and ty by height, tz by width
   logic signed [PROD_W-1:0] txh_ff, tyh_ff, tzw_ff;
   // stage 3: numerator sums and the denominator 2*tz*w
   logic signed [SUM_W-1:0] a_ff, b_ff;
   logic [DEN_W-1:0]        den3_ff, den4_ff;
   // stage 4: times (dim - 1)
   logic signed [NUM_W-1:0] nx_ff, ny_ff;
   // stage 5: magnitude, feeds the divider chain
   cell_type                head_ff;

   logic [DIM_W-1:0] wm1, hm1;
   assign wm1 = cfg.width - DIM_W'(1);
   assign hm1 = cfg.height - DIM_W'(1);

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= {vld_ff[3:0], start && !busy};
   end

   always_ff @(posedge clock) begin
      tx_ff <= TR_W'(req_vertex_x) + TR_W'(cfg.shift_x);
      ty_ff <= TR_W'(req_vertex_y) + TR_W'(cfg.shift_y);
      tz_ff <= TR_W'(req_vertex_z) + TR_W'(cfg.shift_z);

      front1_ff <= tz_ff > 0;
      txh_ff    <= tx_ff * $signed({1'b0, cfg.height});
      tzw_ff    <= tz_ff * $signed({1'b0, cfg.width});
      tyh_ff    <= ty_ff * $signed({1'b0, cfg.height});

      front2_ff <= front1_ff;
      a_ff      <= SUM_W'(txh_ff) + SUM_W'(tzw_ff);
      b_ff      <= SUM_W'(tzw_ff) - SUM_W'(tyh_ff);
      den3_ff   <= {tzw_ff[DEN_W-2:0], 1'b0};

      front3_ff <= front2_ff;
      nx_ff     <= NUM_W'(a_ff * $signed({1'b0, wm1}));
      ny_ff     <= NUM_W'(b_ff * $signed({1'b0, hm1}));
      den4_ff   <= den3_ff;

      head_ff.front   <= front3_ff;
      head_ff.neg_x   <= nx_ff[NUM_W-1];
      head_ff.neg_y   <= ny_ff[NUM_W-1];
      head_ff.rem_x   <= nx_ff[NUM_W-1] ? MAG_W'(-nx_ff) : nx_ff[MAG_W-1:0];
      head_ff.rem_y   <= ny_ff[NUM_W-1] ? MAG_W'(-ny_ff) : ny_ff[MAG_W-1:0];
      head_ff.divisor <= {den4_ff, {(NUM_CELLS-1){1'b0}}};
      head_ff.quo_x   <= '0;
      head_ff.quo_y   <= '0;
   end

   // Divider chain: cell k retires quotient bit NUM_CELLS-1-k. A set top bit
   // means the quotient exceeds the 16-bit range.
   logic     chain_vld [NUM_CELLS+1];
   cell_type chain     [NUM_CELLS+1];

   assign chain_vld[0] = vld_ff[4];
   assign chain[0]     = head_ff;

   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      pp_cell u_cell (
         .clock, .reset,
         .valid_in  (chain_vld[k]),
         .cell_in   (chain[k]),
         .valid_out (chain_vld[k+1]),
         .cell_out  (chain[k+1])
      );
   end

   // saturate and apply sign; C truncation toward zero matches magnitude division
   function automatic logic [15:0] sat_quo(input logic [NUM_CELLS-1:0] q, input logic neg);
      logic [15:0] r;
      if (neg) r = (q > NUM_CELLS'(32768)) ? 16'h8000 : 16'(~q[15:0] + 16'd1);
      else     r = (q > NUM_CELLS'(32767)) ? 16'h7fff : q[15:0];
      return r;
   endfunction

   cell_type    tail;
   logic        sat_vld_ff, sat_front_ff;
   logic [15:0] px_ff, py_ff;
   assign tail = chain[NUM_CELLS];

   always_ff @(posedge clock) begin
      if (reset) sat_vld_ff <= 1'b0;
      else sat_vld_ff <= chain_vld[NUM_CELLS];
   end

   always_ff @(posedge clock) begin
      sat_front_ff <= tail.front;
      px_ff <= tail.front ? sat_quo(tail.quo_x, tail.neg_x) : '0;
      py_ff <= tail.front ? sat_quo(tail.quo_y, tail.neg_y) : '0;
   end

   // output register: screen test and linear index
   logic        on_in;
   logic [15:0] idx_in;
   logic        done_ff, front_ff, on_ff;
   logic [15:0] px_out_ff, py_out_ff, idx_ff;

   always_comb begin
      on_in = sat_front_ff
           && !px_ff[15] && (px_ff[14:0] < 15'(cfg.width))
           && !py_ff[15] && (py_ff[14:0] < 15'(cfg.height));
      idx_in = on_in ? 16'({8'b0, py_ff[7:0]} * {7'b0, cfg.width} + {8'b0, px_ff[7:0]})
                     : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) done_ff <= 1'b0;
      else done_ff <= sat_vld_ff;
   end

   always_ff @(posedge clock) begin
      front_ff  <= sat_front_ff;
      on_ff     <= on_in;
      px_out_ff <= px_ff;
      py_out_ff <= py_ff;
      idx_ff    <= idx_in;
   end

   assign done            = done_ff;
   assign rsp_pixel_x     = $signed(px_out_ff);
   assign rsp_pixel_y     = $signed(py_out_ff);
   assign rsp_in_front    = front_ff;
   assign rsp_on_screen   = on_ff;
   assign rsp_pixel_index = idx_ff;
endmodule
`default_nettype wire

/* src/pp_checker.sv */
`default_nettype none
module pp_checker (
   input wire        clock,
   input wire        reset,
   input wire        start,
   input wire        busy,
   input wire        done,
   input wire [15:0] rsp_pixel_x,
   input wire [15:0] rsp_pixel_y,
   input wire        rsp_in_front,
   input wire        rsp_on_screen,
   input wire [15:0] rsp_pixel_index
);
   import pp_pkg::*;

   a_accept_to_done: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##PIPE_DEPTH done) else $error("word lost in pipeline");

   a_done_has_source: assert property (@(posedge clock) disable iff (reset)
      done |-> $past(start && !busy, PIPE_DEPTH)) else $error("word invented");

   a_screen_needs_front: assert property (@(posedge clock) disable iff (reset)
      (done && rsp_on_screen) |-> rsp_in_front) else $error("on screen behind camera");

   a_behind_zero: assert property (@(posedge clock) disable iff (reset)
      (done && !rsp_in_front) |-> (rsp_pixel_x == 16'd0 && rsp_pixel_y == 16'd0))
      else $error("behind camera with nonzero pixel");

   a_index_zero: assert property (@(posedge clock) disable iff (reset)
      (done && !rsp_on_screen) |-> rsp_pixel_index == 16'd0)
      else $error("off screen with nonzero index");
endmodule

bind point_perspective_project pp_checker u_pp_checker (
   .clock, .reset, .start, .busy, .done, .rsp_pixel_x, .rsp_pixel_y,
   .rsp_in_front, .rsp_on_screen, .rsp_pixel_index
);
`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 100ps
`default_nettype none
// Checks the perspective projection pipeline. Vertices go in on the start/busy
// command port and every word from done is compared in order against a local
// fixed-point projection. The grid size and the translation are changed between
// phases over the csr_ port. Phases rotate through none, heavy, none and light sender idling.
module tb_top;
   import pp_pkg::*;

   localparam int CLK_HALF     = 6;
   localparam int LATENCY      = 25;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int ITEMS_PHASE  = 250;
   localparam int NUM_PHASES   = 7;
   localparam int BAD_REG_ADDR = 20;   // first address past the register list

   typedef struct packed {
      logic signed [15:0] px;
      logic signed [15:0] py;
      logic               front;
      logic               onscr;
      logic [15:0]        index;
   } pixel_word_type;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic               known;   // expected word typed in below
      pixel_word_type     want;
   } vertex_row_type;

   typedef struct packed {
      logic [8:0]         w;
      logic [8:0]         h;
      logic signed [15:0] sx;
      logic signed [15:0] sy;
      logic signed [15:0] sz;
   } grid_setup_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [15:0] vx = '0, vy = '0, vz = '0;
   logic done;
   logic signed [15:0] rsp_px, rsp_py;
   logic rsp_front, rsp_onscr;
   logic [15:0] rsp_index;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [ADDR_W-1:0] csr_paddr = '0;
   logic [DATA_W-1:0] csr_pwdata = '0;
   logic [DATA_W-1:0] csr_prdata;
   logic csr_pready;

   // Copy of the grid registers, kept in step with every csr write.
   logic [8:0]         cur_w  = 9'd80;
   logic [8:0]         cur_h  = 9'd24;
   logic signed [15:0] cur_sx = '0, cur_sy = '0, cur_sz = 16'sd4096;

   pixel_word_type pending_pixels[$];
   int          mismatches = 0;
   int          cycles     = 0;
   int          idle_pct   = 0;

   always #(CLK_HALF) clock = ~clock;

   point_perspective_project i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_vertex_x(vx), .req_vertex_y(vy), .req_vertex_z(vz),
      .done(done), .rsp_pixel_x(rsp_px), .rsp_pixel_y(rsp_py),
      .rsp_in_front(rsp_front), .rsp_on_screen(rsp_onscr),
      .rsp_pixel_index(rsp_index),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   // Grid size register is 9 bits; zero acts as one, anything past 256 as 256.
   function automatic longint grid_dim(logic [8:0] v);
      if (v == 0) return 1;
      if (v > 256) return 256;
      return longint'(v);
   endfunction

   function automatic longint sat_coord(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // The fraction bits cancel in the ratios, so raw integers are used throughout.
   // SV integer division truncates toward zero.
   function automatic pixel_word_type project_vertex(logic signed [15:0] x,
                                                     logic signed [15:0] y,
                                                     logic signed [15:0] z);
      longint w, h, tx, ty, tz, den, px, py;
      pixel_word_type r;
      w  = grid_dim(cur_w);
      h  = grid_dim(cur_h);
      tx = longint'(x) + longint'(cur_sx);
      ty = longint'(y) + longint'(cur_sy);
      tz = longint'(z) + longint'(cur_sz);
      r  = '0;
      if (tz > 0) begin
         den = 2 * tz * w;
         px  = sat_coord(((tx * h + tz * w) * (w - 1)) / den);
         py  = sat_coord(((tz * w - ty * h) * (h - 1)) / den);
         r.front = 1'b1;
         r.px    = px[15:0];
         r.py    = py[15:0];
         r.onscr = px >= 0 && px < w && py >= 0 && py < h;
         if (r.onscr) r.index = 16'(py * w + px);
      end
      return r;
   endfunction

   task automatic csr_write(int addr, logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_W'(addr);
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (addr)
         4 * REG_SCREEN_WIDTH:  cur_w  = data[8:0];
         4 * REG_SCREEN_HEIGHT: cur_h  = data[8:0];
         4 * REG_SHIFT_X:       cur_sx = data[15:0];
         4 * REG_SHIFT_Y:       cur_sy = data[15:0];
         4 * REG_SHIFT_Z:       cur_sz = data[15:0];
         default: ;
      endcase
   endtask

   // Block until nothing is outstanding, then let the pipe drain.
   task automatic drain_pipe();
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic load_grid(grid_setup_type g);
      csr_write(4 * REG_SCREEN_WIDTH,  {23'd0, g.w});
      csr_write(4 * REG_SCREEN_HEIGHT, {23'd0, g.h});
      csr_write(4 * REG_SHIFT_X,       {{16{g.sx[15]}}, g.sx});
      csr_write(4 * REG_SHIFT_Y,       {{16{g.sy[15]}}, g.sy});
      csr_write(4 * REG_SHIFT_Z,       {{16{g.sz[15]}}, g.sz});
      // writes past the register list should change nothing
      csr_write(BAD_REG_ADDR, $urandom());
   endtask

   // Offer one vertex word; returns once it has been taken.
   task automatic send_vertex(logic signed [15:0] x, logic signed [15:0] y,
                              logic signed [15:0] z, logic known,
                              pixel_word_type want);
      logic was_busy;
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct) @(posedge clock);
      end
      start <= 1'b1;
      vx <= x;
      vy <= y;
      vz <= z;
      forever begin
         @(negedge clock);
         was_busy = busy;
         @(posedge clock);
         if (!was_busy) break;
      end
      pending_pixels.push_back(known ? want : project_vertex(x, y, z));
   endtask

   task automatic stop_sending();
      start <= 1'b0;
      @(posedge clock);
   endtask

   // Compare each done word against the oldest outstanding expectation.
   always @(posedge clock) begin
      pixel_word_type want, got;
      if (!reset && done) begin
         got = '{rsp_px, rsp_py, rsp_front, rsp_onscr, rsp_index};
         if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: px=%0d py=%0d front=%b on=%b idx=%0d",
                        got.px, got.py, got.front, got.onscr, got.index);
         end else begin
            want = pending_pixels.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("bad word: want px=%0d py=%0d front=%b on=%b idx=%0d / got px=%0d py=%0d front=%b on=%b idx=%0d",
                           want.px, want.py, want.front, want.onscr, want.index,
                           got.px, got.py, got.front, got.onscr, got.index);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("point_perspective_project: mismatch");
         $finish;
      end
   end

   initial begin
      vertex_row_type directed[$];
      grid_setup_type grids[NUM_PHASES];
      logic signed [15:0] rx, ry, rz;
      int ramp;

      // Directed rows, run at the reset grid (80x24, shift 0,0,1.0).
      // A vertex at the origin lands on the middle pixel: 79/2 and 23/2.
      directed = '{
         '{16'sd0, 16'sd0, 16'sd0, 1'b1, '{16'sd39, 16'sd11, 1'b1, 1'b1, 16'd919}},
         // translated z of zero and below: not in front, all fields zero
         '{16'sd0, 16'sd0, -16'sd4096, 1'b1, '0},
         '{16'sd100, -16'sd7, -16'sd32768, 1'b1, '0},
         '{-16'sd32768, 16'sd32767, -16'sd5000, 1'b1, '0},
         // field extremes, in front
         '{16'sd32767, 16'sd32767, 16'sd32767, 1'b0, '0},
         '{-16'sd32768, -16'sd32768, 16'sd32767, 1'b0, '0},
         '{16'sd32767, -16'sd32768, -16'sd4095, 1'b0, '0},
         '{-16'sd32768, 16'sd32767, -16'sd4095, 1'b0, '0},
         // left and right screen edges and just outside them
         '{-16'sd13653, 16'sd4096, 16'sd0, 1'b0, '0},
         '{16'sd13653, -16'sd4096, 16'sd0, 1'b0, '0},
         '{-16'sd14000, 16'sd4500, 16'sd0, 1'b0, '0},
         '{16'sd14000, -16'sd4500, 16'sd0, 1'b0, '0},
         // slightly negative pixel truncates toward zero
         '{-16'sd13700, 16'sd4120, 16'sd0, 1'b0, '0},
         // tiny positive z: projection saturates; then a far vertex near the centre
         '{16'sd30000, -16'sd30000, -16'sd4095, 1'b0, '0},
         '{16'sd1, 16'sd1, 16'sd28672, 1'b0, '0}
      };

      // Grid settings, extremes among them; zero and oversize dims clamp.
      grids = '{
         '{9'd80, 9'd24, 16'sd0, 16'sd0, 16'sd4096},
         '{9'd256, 9'd256, 16'sd0, 16'sd0, 16'sd4096},
         '{9'd0, 9'd0, 16'sd512, -16'sd512, 16'sd8192},
         '{9'd511, 9'd300, -16'sd32768, 16'sd32767, 16'sd32767},
         '{9'd1, 9'd256, 16'sd32767, -16'sd32768, -16'sd32768},
         '{9'd257, 9'd2, 16'sd1000, -16'sd2000, 16'sd12288},
         '{9'd160, 9'd120, -16'sd300, 16'sd700, 16'sd6000}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         send_vertex(directed[i].x, directed[i].y, directed[i].z,
                     directed[i].known, directed[i].want);
      stop_sending();
      drain_pipe();

      for (int p = 0; p < NUM_PHASES; p++) begin
         load_grid(grids[p]);
         // idling per phase: none, heavy, none, light
         case (p % 4)
            1: idle_pct = 87;
            3: idle_pct = 18;
            default: idle_pct = 0;
         endcase
         for (int n = 0; n < ITEMS_PHASE; n++) begin
            // a quiet stretch in every phase
            ramp = (n >= 100 && n < 130) ? 0 : idle_pct;
            idle_pct = ramp == 0 ? 0 : idle_pct;
            if (n == 130)
               case (p % 4)
                  1: idle_pct = 87;
                  3: idle_pct = 18;
                  default: idle_pct = 0;
               endcase
            if ($urandom_range(99) < 60) begin
               // mostly points near the view volume, so pixels land on screen
               rx = 16'($signed($urandom_range(16384)) - 8192);
               ry = 16'($signed($urandom_range(16384)) - 8192);
               rz = 16'($signed($urandom_range(16384)) - 4096);
            end else begin
               rx = 16'($urandom());
               ry = 16'($urandom());
               rz = 16'($urandom());
            end
            send_vertex(rx, ry, rz, 1'b0, '0);
            // hold off once mid-phase until everything has come back
            if (n == 200 && p == 2) begin
               stop_sending();
               while (pending_pixels.size() != 0) @(posedge clock);
            end
         end
         stop_sending();
         drain_pipe();
      end

      if (mismatches == 0 && pending_pixels.size() == 0)
         $display("point_perspective_project: match");
      else
         $display("point_perspective_project: mismatch");
      $finish;
   end

endmodule
`default_nettype wire
